### sv/dhs_pkg.sv
// shared types, constants and tables of the differential heading steering block
package dhs_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POW_STEPS         = 15;

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_SHARP     = 2'd1;
  localparam logic [1:0] REG_TRIM      = 2'd2;

  localparam logic [14:0] MAX_SPEED_RST = 15'd16384;
  localparam logic [3:0]  SHARP_RST     = 4'd1;
  localparam logic [15:0] TRIM_RST      = 16'd16384;

  // stage kinds
  localparam int K_PROD  = 0;
  localparam int K_SUM   = 1;
  localparam int K_PREP  = 2;
  localparam int K_NORM  = 3;
  localparam int K_VEC   = 4;
  localparam int K_ANG   = 5;
  localparam int K_ROT   = 6;
  localparam int K_CLAMP = 7;
  localparam int K_POW   = 8;
  localparam int K_SLOW  = 9;
  localparam int K_TRIM  = 10;

  typedef struct packed {
    logic               empty;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [31:0] pww;
    logic signed [31:0] pxx;
    logic signed [31:0] pyy;
    logic signed [31:0] pzz;
    logic signed [31:0] pxy;
    logic signed [31:0] pwz;
    logic signed [43:0] vx0;
    logic signed [43:0] vy0;
    logic signed [33:0] vz0;
    logic [5:0]         sh0;
    logic               zero0;
    logic signed [43:0] vx1;
    logic signed [43:0] vy1;
    logic signed [33:0] vz1;
    logic [5:0]         sh1;
    logic               zero1;
    logic signed [33:0] errv;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] ca;
    logic               cneg;
    logic signed [31:0] cv;
    logic signed [31:0] pw;
    logic signed [16:0] slowed;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pipe_t;

  // atan(2^-i) in q32 turns
  function automatic logic [31:0] atan_q32(input int idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10680862;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic int num_stages(input int cs);
    return 9 + 2 * cs + POW_STEPS;
  endfunction

  function automatic int stage_kind(input int i, input int cs);
    int k;
    if (i == 1) k = K_PROD;
    else if (i == 2) k = K_SUM;
    else if (i == 3) k = K_PREP;
    else if (i == 4) k = K_NORM;
    else if (i < 5 + cs) k = K_VEC;
    else if (i == 5 + cs) k = K_ANG;
    else if (i < 6 + 2 * cs) k = K_ROT;
    else if (i == 6 + 2 * cs) k = K_CLAMP;
    else if (i < 7 + 2 * cs + POW_STEPS) k = K_POW;
    else if (i == 7 + 2 * cs + POW_STEPS) k = K_SLOW;
    else k = K_TRIM;
    return k;
  endfunction

  function automatic int stage_iter(input int i, input int cs);
    int t;
    if (i >= 5 && i < 5 + cs) t = i - 5;
    else if (i >= 6 + cs && i < 6 + 2 * cs) t = i - 6 - cs;
    else if (i >= 7 + 2 * cs && i < 7 + 2 * cs + POW_STEPS) t = i - 7 - 2 * cs;
    else t = 0;
    return t;
  endfunction

endpackage

### sv/dhs_if.sv
// valid/ready channel interfaces for pose transactions and throttle transactions
interface dhs_in_if;
  logic               valid;
  logic               ready;
  logic               path_empty;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] waypoint_x;
  logic signed [31:0] waypoint_y;

  modport source (output valid, path_empty, pose_x, pose_y, quat_w, quat_x, quat_y, quat_z,
                  waypoint_x, waypoint_y, input ready);
  modport sink (input valid, path_empty, pose_x, pose_y, quat_w, quat_x, quat_y, quat_z,
                waypoint_x, waypoint_y, output ready);
endinterface

interface dhs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

### sv/dhs_stage.sv
// one pipeline step of the steering datapath, chosen by kind and iteration
module dhs_stage #(
  parameter int KIND       = dhs_pkg::K_PROD,
  parameter int ITER       = 0,
  parameter int ANGLE_BITS = dhs_pkg::ANGLE_BITS_DEF
) (
  input  dhs_pkg::pipe_t d,
  input  logic [14:0]    speed,
  input  logic [3:0]     sharp,
  input  logic [15:0]    gain,
  output dhs_pkg::pipe_t q
);

  localparam int SH = 32 - ANGLE_BITS;
  localparam logic signed [33:0] ATAN = 34'(dhs_pkg::atan_q32(ITER));
  localparam logic signed [33:0] HALF_Q32 = 34'sd2147483648;
  localparam logic signed [33:0] QUART_Q32 = 34'sd1073741824;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] RND_ANG = 34'sd1 <<< (SH - 1);

  function automatic logic [5:0] norm_shift(input logic signed [43:0] x,
                                            input logic signed [43:0] y);
    logic [43:0] ax, ay, m;
    logic [5:0] s;
    ax = x[43] ? 44'(-x) : 44'(x);
    ay = y[43] ? 44'(-y) : 44'(y);
    m = ax | ay;
    s = 6'd0;
    for (int b = 0; b < 40; b++) begin
      if (m[b]) s = 6'(40 - b);
    end
    if (|m[43:40]) s = 6'd0;
    return s;
  endfunction

  logic signed [43:0] nx0, ny0, nx1, ny1;
  logic signed [33:0] hq, bq, errw, av, cxs, cys;
  logic [ANGLE_BITS-1:0] pa;
  logic [31:0] qv;
  logic signed [63:0] prod;
  logic signed [48:0] sprod;
  logic signed [33:0] tprod, rq;
  logic signed [16:0] rsel, lsel;

  always_comb begin
    q = d;
    nx0 = '0; ny0 = '0; nx1 = '0; ny1 = '0;
    hq = '0; bq = '0; errw = '0; av = '0; cxs = '0; cys = '0;
    pa = '0; qv = '0; prod = '0; sprod = '0; tprod = '0; rq = '0;
    rsel = '0; lsel = '0;
    unique case (KIND)
      dhs_pkg::K_PROD: begin
        q.pww = 32'(d.qw) * 32'(d.qw);
        q.pxx = 32'(d.qx) * 32'(d.qx);
        q.pyy = 32'(d.qy) * 32'(d.qy);
        q.pzz = 32'(d.qz) * 32'(d.qz);
        q.pxy = 32'(d.qx) * 32'(d.qy);
        q.pwz = 32'(d.qw) * 32'(d.qz);
      end
      dhs_pkg::K_SUM: begin
        q.vx0 = 44'(d.pww) + 44'(d.pxx) - 44'(d.pyy) - 44'(d.pzz);
        q.vy0 = (44'(d.pxy) + 44'(d.pwz)) <<< 1;
        q.vx1 = 44'(d.wx) - 44'(d.px);
        q.vy1 = 44'(d.wy) - 44'(d.py);
      end
      dhs_pkg::K_PREP: begin
        // left half plane is turned by a half turn first
        q.zero0 = (d.vx0 == 0) && (d.vy0 == 0);
        q.zero1 = (d.vx1 == 0) && (d.vy1 == 0);
        nx0 = d.vx0; ny0 = d.vy0; q.vz0 = '0;
        if (d.vx0 < 0) begin
          nx0 = -d.vx0; ny0 = -d.vy0;
          q.vz0 = (d.vy0 >= 0) ? HALF_Q32 : -HALF_Q32;
        end
        nx1 = d.vx1; ny1 = d.vy1; q.vz1 = '0;
        if (d.vx1 < 0) begin
          nx1 = -d.vx1; ny1 = -d.vy1;
          q.vz1 = (d.vy1 >= 0) ? HALF_Q32 : -HALF_Q32;
        end
        q.vx0 = nx0; q.vy0 = ny0; q.vx1 = nx1; q.vy1 = ny1;
        q.sh0 = norm_shift(nx0, ny0);
        q.sh1 = norm_shift(nx1, ny1);
      end
      dhs_pkg::K_NORM: begin
        q.vx0 = d.vx0 <<< d.sh0; q.vy0 = d.vy0 <<< d.sh0;
        q.vx1 = d.vx1 <<< d.sh1; q.vy1 = d.vy1 <<< d.sh1;
      end
      dhs_pkg::K_VEC: begin
        if (d.vy0 > 0) begin
          q.vx0 = d.vx0 + (d.vy0 >>> ITER); q.vy0 = d.vy0 - (d.vx0 >>> ITER);
          q.vz0 = d.vz0 + ATAN;
        end else begin
          q.vx0 = d.vx0 - (d.vy0 >>> ITER); q.vy0 = d.vy0 + (d.vx0 >>> ITER);
          q.vz0 = d.vz0 - ATAN;
        end
        if (d.vy1 > 0) begin
          q.vx1 = d.vx1 + (d.vy1 >>> ITER); q.vy1 = d.vy1 - (d.vx1 >>> ITER);
          q.vz1 = d.vz1 + ATAN;
        end else begin
          q.vx1 = d.vx1 - (d.vy1 >>> ITER); q.vy1 = d.vy1 + (d.vx1 >>> ITER);
          q.vz1 = d.vz1 - ATAN;
        end
      end
      dhs_pkg::K_ANG: begin
        hq = d.zero0 ? 34'sd0 : ((d.vz0 + RND_ANG) >>> SH);
        bq = d.zero1 ? 34'sd0 : ((d.vz1 + RND_ANG) >>> SH);
        errw = hq - bq;
        q.errv = errw;
        // doubled error wrapped to one turn, back in q32 turns
        pa = {errw[ANGLE_BITS-2:0], 1'b0};
        qv = {pa, SH'(0)};
        av = 34'($signed(qv));
        q.cneg = 1'b0;
        if (av > QUART_Q32) begin
          av = av - HALF_Q32; q.cneg = 1'b1;
        end else if (av < -QUART_Q32) begin
          av = av + HALF_Q32; q.cneg = 1'b1;
        end
        q.ca = av;
        q.cx = 34'sd652032874;
        q.cy = '0;
      end
      dhs_pkg::K_ROT: begin
        cxs = d.cx >>> ITER;
        cys = d.cy >>> ITER;
        if (d.ca >= 0) begin
          q.cx = d.cx - cys; q.cy = d.cy + cxs; q.ca = d.ca - ATAN;
        end else begin
          q.cx = d.cx + cys; q.cy = d.cy - cxs; q.ca = d.ca + ATAN;
        end
      end
      dhs_pkg::K_CLAMP: begin
        cxs = d.cx;
        if (cxs > ONE_Q30) cxs = ONE_Q30;
        if (cxs < -ONE_Q30) cxs = -ONE_Q30;
        q.cv = d.cneg ? 32'(-cxs) : 32'(cxs);
        q.pw = 32'sd1073741824;
      end
      dhs_pkg::K_POW: begin
        prod = 64'(d.pw) * 64'(d.cv) + 64'sd536870912;
        if (4'(ITER) < sharp) q.pw = 32'(prod >>> 30);
      end
      dhs_pkg::K_SLOW: begin
        sprod = 49'($signed({1'b0, speed})) * 49'(d.pw) + 49'sd536870912;
        q.slowed = 17'(sprod >>> 30);
      end
      dhs_pkg::K_TRIM: begin
        if (d.errv > 0) begin
          lsel = d.slowed; rsel = 17'($signed({2'b0, speed}));
        end else begin
          lsel = 17'($signed({2'b0, speed})); rsel = d.slowed;
        end
        tprod = 34'(rsel) * 34'($signed({1'b0, gain})) + 34'sd8192;
        rq = tprod >>> 14;
        if (rq > 34'sd32767) rq = 34'sd32767;
        if (rq < -34'sd32767) rq = -34'sd32767;
        q.left = d.empty ? 16'sd0 : 16'(lsel);
        q.right = d.empty ? 16'sd0 : 16'(rq);
      end
      default: q = d;
    endcase
  end

endmodule

### sv/differential_heading_steering_core.sv
// Differential heading steering core. Each pose transaction (position, orientation quaternion,
// next waypoint) yields one throttle transaction: heading and bearing come from two parallel
// vectoring CORDIC lanes, the cosine of the doubled heading error from a rotation CORDIC, and
// the power from a chain of fifteen single-multiplier stages. The pipeline holds
// 9 + 2*CORDIC_STAGES + 15 register stages (56 at the default); an accepted pose transaction
// is captured in the first stage and its result is offered from the last. One transaction
// enters per cycle while the input is ready, and each stage only stalls when the stage after it is
// full, so a waiting result blocks the input only once every stage holds a transaction.
// Registers over APB at byte offsets 0 (max wheel speed), 4 (turn sharpness) and 8 (right
// trim gain) must be written while idle.
module differential_heading_steering_core #(
  parameter int ANGLE_BITS    = dhs_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = dhs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dhs_in_if.sink                     in_ch,
  dhs_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dhs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int NST = dhs_pkg::num_stages(CORDIC_STAGES);

  logic [14:0] speed_r;
  logic [3:0]  sharp_r;
  logic [15:0] gain_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= dhs_pkg::MAX_SPEED_RST;
      sharp_r <= dhs_pkg::SHARP_RST;
      gain_r  <= dhs_pkg::TRIM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        dhs_pkg::REG_MAX_SPEED: speed_r <= pwdata[14:0];
        dhs_pkg::REG_SHARP:     sharp_r <= pwdata[3:0];
        dhs_pkg::REG_TRIM:      gain_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dhs_pkg::REG_MAX_SPEED: prdata = {17'd0, speed_r};
      dhs_pkg::REG_SHARP:     prdata = {28'd0, sharp_r};
      dhs_pkg::REG_TRIM:      prdata = {16'd0, gain_r};
      default:                prdata = '0;
    endcase
  end

  dhs_pkg::pipe_t st_r [NST];
  dhs_pkg::pipe_t st_nxt [NST];
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  // each stage takes new data when it is empty or its successor moves
  assign rdy[NST] = out_ch.ready;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = !v_r[i] || rdy[i+1];
  end
  assign in_ch.ready = rdy[0];

  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].empty = in_ch.path_empty;
    st_nxt[0].px = in_ch.pose_x;
    st_nxt[0].py = in_ch.pose_y;
    st_nxt[0].qw = in_ch.quat_w;
    st_nxt[0].qx = in_ch.quat_x;
    st_nxt[0].qy = in_ch.quat_y;
    st_nxt[0].qz = in_ch.quat_z;
    st_nxt[0].wx = in_ch.waypoint_x;
    st_nxt[0].wy = in_ch.waypoint_y;
  end

  for (genvar i = 1; i < NST; i++) begin : g_stage
    dhs_stage #(
      .KIND       (dhs_pkg::stage_kind(i, CORDIC_STAGES)),
      .ITER       (dhs_pkg::stage_iter(i, CORDIC_STAGES)),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_stage (
      .d     (st_r[i-1]),
      .speed (speed_r),
      .sharp (sharp_r),
      .gain  (gain_r),
      .q     (st_nxt[i])
    );
  end

  for (genvar i = 0; i < NST; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= (i == 0) ? in_ch.valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_ch.valid       = v_r[NST-1];
  assign out_ch.left_drive  = st_r[NST-1].left;
  assign out_ch.right_drive = st_r[NST-1].right;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted transaction not captured in first stage");

  a_cfg_sharp: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && paddr[3:2] == dhs_pkg::REG_SHARP |=> sharp_r == $past(pwdata[3:0]))
    else $error("sharpness register write lost");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.right_drive != 16'sh8000 && out_ch.left_drive != 16'sh8000)
    else $error("throttle outside symmetric range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && st_r[NST-1].empty |-> out_ch.left_drive == 16'sd0
      && out_ch.right_drive == 16'sd0)
    else $error("empty path gave nonzero throttle");

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the differential heading steering core
`timescale 1ns / 1ps

module testbench;

  localparam int  LATENCY = dhs_pkg::num_stages(dhs_pkg::CORDIC_STAGES_DEF);
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint GAIN_INV_Q30 = 64'sd652032874;
  localparam longint NORM_LIMIT = 64'sd1 << 40;

  typedef struct packed {
    logic               path_empty;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] waypoint_x;
    logic signed [31:0] waypoint_y;
  } pose_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } throttle_t;

  class throttle_scoreboard;
    throttle_t pending[$];
    logic [14:0] max_speed = dhs_pkg::MAX_SPEED_RST;
    logic [3:0]  sharpness = dhs_pkg::SHARP_RST;
    logic [15:0] trim_gain = dhs_pkg::TRIM_RST;
    int errors = 0;

    function longint iabs(longint v);
      return v < 0 ? -v : v;
    endfunction

    // atan2 in q32 turns
    function longint atan2_q32(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN : -HALF_TURN;
        x = -x;
        y = -y;
      end
      while (iabs(x) < NORM_LIMIT && iabs(y) < NORM_LIMIT) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < dhs_pkg::CORDIC_STAGES_DEF; i++) begin
        ys = y >>> i;
        xs = x >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(dhs_pkg::atan_q32(i));
        end else begin
          x -= ys; y += xs; z -= longint'(dhs_pkg::atan_q32(i));
        end
      end
      return z;
    endfunction

    function longint to_bam(longint q32);
      return (q32 + (64'sd1 << 15)) >>> 16;
    endfunction

    function longint cosine_q30(longint ang);
      longint q, a, x, y, xs, ys;
      bit neg;
      neg = 0;
      q = (ang & 64'hFFFF) << 16;
      a = (q >= HALF_TURN) ? q - 2 * HALF_TURN : q;
      x = GAIN_INV_Q30;
      y = 0;
      if (a > QUARTER_TURN) begin
        a -= HALF_TURN; neg = 1;
      end else if (a < -QUARTER_TURN) begin
        a += HALF_TURN; neg = 1;
      end
      for (int i = 0; i < dhs_pkg::CORDIC_STAGES_DEF; i++) begin
        ys = y >>> i;
        xs = x >>> i;
        if (a >= 0) begin
          x -= ys; y += xs; a -= longint'(dhs_pkg::atan_q32(i));
        end else begin
          x += ys; y -= xs; a += longint'(dhs_pkg::atan_q32(i));
        end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -ONE_Q30) x = -ONE_Q30;
      return neg ? -x : x;
    endfunction

    function void note_pose(pose_item_t it);
      longint qw, qx, qy, qz, fx, fy, heading, bearing, err, c, pw, slowed, speed, l, r;
      throttle_t t;
      if (it.path_empty) begin
        t = '0;
      end else begin
        speed = longint'(max_speed);
        qw = it.quat_w; qx = it.quat_x; qy = it.quat_y; qz = it.quat_z;
        fx = qw * qw + qx * qx - qy * qy - qz * qz;
        fy = 2 * (qx * qy + qw * qz);
        heading = to_bam(atan2_q32(fx, fy));
        bearing = to_bam(atan2_q32(longint'(it.waypoint_x) - longint'(it.pose_x),
                                   longint'(it.waypoint_y) - longint'(it.pose_y)));
        err = heading - bearing;
        c = cosine_q30(2 * err);
        pw = ONE_Q30;
        for (int k = 0; k < sharpness; k++) pw = (pw * c + (64'sd1 << 29)) >>> 30;
        slowed = (speed * pw + (64'sd1 << 29)) >>> 30;
        if (err > 0) begin
          l = slowed; r = speed;
        end else begin
          l = speed; r = slowed;
        end
        r = (r * longint'(trim_gain) + 8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        t.left = l[15:0];
        t.right = r[15:0];
      end
      pending.push_back(t);
    endfunction

    function void check_throttle(logic [15:0] l, logic [15:0] r);
      throttle_t t;
      if (pending.size() == 0) begin
        $error("throttle transaction with none expected: left %0d right %0d",
               $signed(l), $signed(r));
        errors++;
        return;
      end
      t = pending.pop_front();
      if (l !== t.left) begin
        $error("left_drive expected %0d actual %0d", t.left, $signed(l));
        errors++;
      end
      if (r !== t.right) begin
        $error("right_drive expected %0d actual %0d", t.right, $signed(r));
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [dhs_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dhs_in_if in_ch ();
  dhs_out_if out_ch ();

  differential_heading_steering_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  throttle_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    {in_ch.path_empty, in_ch.pose_x, in_ch.pose_y, in_ch.quat_w, in_ch.quat_x,
     in_ch.quat_y, in_ch.quat_z, in_ch.waypoint_x, in_ch.waypoint_y} = '0;
    out_ch.ready = 0;
  end

  // receiver, with the long hold-off counted here
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_throttle(out_ch.left_drive, out_ch.right_drive);
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pose(pose_item_t it);
    in_ch.valid <= 1'b1;
    {in_ch.path_empty, in_ch.pose_x, in_ch.pose_y, in_ch.quat_w, in_ch.quat_x,
     in_ch.quat_y, in_ch.quat_z, in_ch.waypoint_x, in_ch.waypoint_y} <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pose(it);
    // each cycle is idle with the given odds
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= dhs_pkg::CFG_AW'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      dhs_pkg::REG_MAX_SPEED: sb.max_speed = value[14:0];
      dhs_pkg::REG_SHARP:     sb.sharpness = value[3:0];
      dhs_pkg::REG_TRIM:      sb.trim_gain = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] speed, logic [31:0] sharp, logic [31:0] gain);
    write_reg(dhs_pkg::REG_MAX_SPEED, speed);
    write_reg(dhs_pkg::REG_SHARP, sharp);
    write_reg(dhs_pkg::REG_TRIM, gain);
  endtask

  function automatic pose_item_t random_pose();
    pose_item_t it;
    int mode;
    it = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(9);
    it.path_empty = (mode == 0);
    if (mode >= 4) begin
      // nearby waypoints, moderate coordinates
      it.pose_x = $signed(it.pose_x) >>> $urandom_range(12);
      it.pose_y = $signed(it.pose_y) >>> $urandom_range(12);
      it.waypoint_x = it.pose_x + ($signed($urandom) >>> $urandom_range(31, 8));
      it.waypoint_y = it.pose_y + ($signed($urandom) >>> $urandom_range(31, 8));
    end
    if (mode == 1) begin
      it.waypoint_x = it.pose_x;
      it.waypoint_y = it.pose_y;
    end
    if (mode == 2) {it.quat_w, it.quat_x, it.quat_y, it.quat_z} = '0;
    return it;
  endfunction

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_pose(random_pose());
  endtask

  task automatic run_directed();
    pose_item_t it;
    int q[4] = '{32767, -32768, 0, 23170};
    it = '0;
    it.path_empty = 1'b1;
    send_pose(it);
    it = '1;
    send_pose(it);
    it = '0;
    send_pose(it);  // waypoint on the robot, zero forward axis
    for (int i = 0; i < 4; i++) begin
      it = '0;
      it.quat_w = 16'(q[i]);
      it.quat_z = 16'(q[(i + 1) % 4]);
      it.waypoint_x = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      it.waypoint_y = (i < 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
      it.pose_x = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
      send_pose(it);
    end
    for (int i = 0; i < 8; i++) begin
      // quarter-turn headings of both signs against four bearings on and below the x axis
      it = '0;
      it.quat_w = 16'sd23170;
      it.quat_z = (i % 2) ? -16'sd23170 : 16'sd23170;
      it.waypoint_x = (i & 2) ? -65536 : 65536;
      it.waypoint_y = (i & 4) ? -65536 : 0;
      send_pose(it);
    end
    it = '0;
    it.quat_x = 16'sd32767;
    it.quat_y = 16'sd32767;
    it.waypoint_y = 1;
    send_pose(it);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(32'(dhs_pkg::MAX_SPEED_RST), 32'(dhs_pkg::SHARP_RST), 32'(dhs_pkg::TRIM_RST));
    run_directed();
    run_random(60, 0, 0);
    drain();
    set_config(32767, 15, 65535);
    run_directed();
    run_random(80, 77, 0);
    drain();
    set_config(0, 0, 0);
    run_random(40, 0, 77);
    drain();
    set_config(32'hffff_ffff, 3, 16384);
    // receiver holds off while the sender keeps offering
    hold_off = 400;
    run_random(120, 0, 0);
    drain();
    set_config({$urandom} & 32'h7fff, $urandom_range(15), $urandom_range(65535));
    run_random(100, 24, 24);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
sv/dhs_pkg.sv
sv/dhs_if.sv
sv/dhs_stage.sv
sv/differential_heading_steering_core.sv
tb/sv/testbench.sv
